// ===== hw/rtl/rpi_pkg.sv =====
`default_nettype none

package rpi_pkg;

   // coordinate width of every input field
   localparam int COORD_BITS = 16;
   // a difference of two coordinates
   localparam int DIFF_BITS  = COORD_BITS + 1;
   // a product of two differences
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   // a sum or difference of two products
   localparam int SUM_BITS   = PROD_BITS + 1;

   // one request word: both rays
   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] dx;
      logic signed [COORD_BITS-1:0] dy;
   } coord_type;

   // directions of both rays and the offset between their origins
   typedef struct packed {
      logic signed [DIFF_BITS-1:0] d1x;
      logic signed [DIFF_BITS-1:0] d1y;
      logic signed [DIFF_BITS-1:0] d2x;
      logic signed [DIFF_BITS-1:0] d2y;
      logic signed [DIFF_BITS-1:0] wx;
      logic signed [DIFF_BITS-1:0] wy;
      logic                        degen;
   } diff_type;

   // all partial products of the cross and dot products
   typedef struct packed {
      logic signed [PROD_BITS-1:0] d1x_d2y;
      logic signed [PROD_BITS-1:0] d1y_d2x;
      logic signed [PROD_BITS-1:0] wx_d2y;
      logic signed [PROD_BITS-1:0] wy_d2x;
      logic signed [PROD_BITS-1:0] wx_d1y;
      logic signed [PROD_BITS-1:0] wy_d1x;
      logic signed [PROD_BITS-1:0] wx_d1x;
      logic signed [PROD_BITS-1:0] wy_d1y;
      logic signed [PROD_BITS-1:0] wx_d2x;
      logic signed [PROD_BITS-1:0] wy_d2y;
      logic                        degen;
   } prod_type;

   // finished cross and dot products
   typedef struct packed {
      logic signed [SUM_BITS-1:0] den;
      logic signed [SUM_BITS-1:0] nt;
      logic signed [SUM_BITS-1:0] nu;
      logic signed [SUM_BITS-1:0] dot1;
      logic signed [SUM_BITS-1:0] dot2;
      logic                       degen;
   } sum_type;

   // one response word
   typedef struct packed {
      logic rays_meet;
      logic degenerate_ray;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rpi_diff.sv =====
`default_nettype none

module rpi_diff (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire rpi_pkg::coord_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output rpi_pkg::diff_type       out_data,
   input  wire logic               out_ready
);

   logic              valid_ff;
   rpi_pkg::diff_type data_ff;
   rpi_pkg::diff_type data_in;

   // stage moves when empty or when downstream takes its word
   assign in_ready = !valid_ff || out_ready;

   // coordinate differences and degenerate ray detection
   always_comb begin
      data_in.d1x   = rpi_pkg::DIFF_BITS'(in_data.bx) - rpi_pkg::DIFF_BITS'(in_data.ax);
      data_in.d1y   = rpi_pkg::DIFF_BITS'(in_data.by) - rpi_pkg::DIFF_BITS'(in_data.ay);
      data_in.d2x   = rpi_pkg::DIFF_BITS'(in_data.dx) - rpi_pkg::DIFF_BITS'(in_data.cx);
      data_in.d2y   = rpi_pkg::DIFF_BITS'(in_data.dy) - rpi_pkg::DIFF_BITS'(in_data.cy);
      data_in.wx    = rpi_pkg::DIFF_BITS'(in_data.cx) - rpi_pkg::DIFF_BITS'(in_data.ax);
      data_in.wy    = rpi_pkg::DIFF_BITS'(in_data.cy) - rpi_pkg::DIFF_BITS'(in_data.ay);
      data_in.degen = ((in_data.ax == in_data.bx) && (in_data.ay == in_data.by)) ||
                      ((in_data.cx == in_data.dx) && (in_data.cy == in_data.dy));
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rpi_mult.sv =====
`default_nettype none

module rpi_mult (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire rpi_pkg::diff_type in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output rpi_pkg::prod_type      out_data,
   input  wire logic              out_ready
);

   logic              valid_ff;
   rpi_pkg::prod_type data_ff;
   rpi_pkg::prod_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // ten signed multipliers, one register level after them
   always_comb begin
      data_in.d1x_d2y = in_data.d1x * in_data.d2y;
      data_in.d1y_d2x = in_data.d1y * in_data.d2x;
      data_in.wx_d2y  = in_data.wx  * in_data.d2y;
      data_in.wy_d2x  = in_data.wy  * in_data.d2x;
      data_in.wx_d1y  = in_data.wx  * in_data.d1y;
      data_in.wy_d1x  = in_data.wy  * in_data.d1x;
      data_in.wx_d1x  = in_data.wx  * in_data.d1x;
      data_in.wy_d1y  = in_data.wy  * in_data.d1y;
      data_in.wx_d2x  = in_data.wx  * in_data.d2x;
      data_in.wy_d2y  = in_data.wy  * in_data.d2y;
      data_in.degen   = in_data.degen;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rpi_sum.sv =====
`default_nettype none

module rpi_sum (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire rpi_pkg::prod_type in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   output rpi_pkg::sum_type       out_data,
   input  wire logic              out_ready
);

   logic             valid_ff;
   rpi_pkg::sum_type data_ff;
   rpi_pkg::sum_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // cross products and dot products from the partial products
   always_comb begin
      data_in.den   = rpi_pkg::SUM_BITS'(in_data.d1x_d2y) - rpi_pkg::SUM_BITS'(in_data.d1y_d2x);
      data_in.nt    = rpi_pkg::SUM_BITS'(in_data.wx_d2y)  - rpi_pkg::SUM_BITS'(in_data.wy_d2x);
      data_in.nu    = rpi_pkg::SUM_BITS'(in_data.wx_d1y)  - rpi_pkg::SUM_BITS'(in_data.wy_d1x);
      data_in.dot1  = rpi_pkg::SUM_BITS'(in_data.wx_d1x)  + rpi_pkg::SUM_BITS'(in_data.wy_d1y);
      data_in.dot2  = rpi_pkg::SUM_BITS'(in_data.wx_d2x)  + rpi_pkg::SUM_BITS'(in_data.wy_d2y);
      data_in.degen = in_data.degen;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rpi_decide.sv =====
`default_nettype none

module rpi_decide (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire rpi_pkg::sum_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output rpi_pkg::result_type   out_data,
   input  wire logic             out_ready
);

   localparam int MSB = rpi_pkg::SUM_BITS - 1;

   logic                valid_ff;
   rpi_pkg::result_type data_ff;
   rpi_pkg::result_type data_in;
   logic                t_ok;
   logic                u_ok;
   logic                c_on_first;
   logic                a_on_second;
   logic                meet;

   assign in_ready = !valid_ff || out_ready;

   // sign tests on the crossing parameters and the parallel case
   always_comb begin
      // zero parameter counts as on the ray, else its sign must match den
      t_ok        = (in_data.nt == '0) || (in_data.nt[MSB] == in_data.den[MSB]);
      u_ok        = (in_data.nu == '0) || (in_data.nu[MSB] == in_data.den[MSB]);
      // second origin on first ray: collinear and not behind it
      c_on_first  = (in_data.nu == '0) && !in_data.dot1[MSB];
      // first origin on second ray: offset points against its direction
      a_on_second = (in_data.nt == '0) && ((in_data.dot2 == '0) || in_data.dot2[MSB]);
      if (in_data.den != '0) begin
         meet = t_ok && u_ok;
      end else begin
         meet = c_on_first || a_on_second;
      end
      data_in.rays_meet      = meet && !in_data.degen;
      data_in.degenerate_ray = in_data.degen;
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // output register data
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ray_pair_intersection_test.sv =====
// four register stages: differences, products, cross and dot products, sign tests;
//    an accepted word passes them in order; the last one drives rsp
// throughput: one word per cycle while rsp_stall is low; all stages are pipelined
// a stall holds only full stages up to rsp; bubbles ahead of a stall are filled
// reset clears all stage valid bits; rsp_valid is low in the cycle after reset
`default_nettype none

module ray_pair_intersection_test (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_y,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_y,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_origin_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_origin_y,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_through_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_through_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_rays_meet,
   output logic                                   rsp_degenerate_ray
);

   rpi_pkg::coord_type  req_word;
   rpi_pkg::diff_type   diff_word;
   rpi_pkg::prod_type   prod_word;
   rpi_pkg::sum_type    sum_word;
   rpi_pkg::result_type rsp_word;
   logic                diff_ready;
   logic                diff_valid;
   logic                mult_ready;
   logic                prod_valid;
   logic                sum_ready;
   logic                sum_valid;
   logic                decide_ready;

   // pack the request fields
   always_comb begin
      req_word.ax = req_first_origin_x;
      req_word.ay = req_first_origin_y;
      req_word.bx = req_first_through_x;
      req_word.by = req_first_through_y;
      req_word.cx = req_second_origin_x;
      req_word.cy = req_second_origin_y;
      req_word.dx = req_second_through_x;
      req_word.dy = req_second_through_y;
   end

   assign req_stall = !diff_ready;

   // stage one: differences
   rpi_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_word),
      .in_ready  (diff_ready),
      .out_valid (diff_valid),
      .out_data  (diff_word),
      .out_ready (mult_ready)
   );

   // stage two: products
   rpi_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (diff_valid),
      .in_data   (diff_word),
      .in_ready  (mult_ready),
      .out_valid (prod_valid),
      .out_data  (prod_word),
      .out_ready (sum_ready)
   );

   // stage three: cross and dot products
   rpi_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_data   (prod_word),
      .in_ready  (sum_ready),
      .out_valid (sum_valid),
      .out_data  (sum_word),
      .out_ready (decide_ready)
   );

   // stage four: sign tests and output register
   rpi_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_data   (sum_word),
      .in_ready  (decide_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_word),
      .out_ready (!rsp_stall)
   );

   assign rsp_rays_meet      = rsp_word.rays_meet;
   assign rsp_degenerate_ray = rsp_word.degenerate_ray;

endmodule

`default_nettype wire

// ===== hw/rtl/rpi_checker.sv =====
`default_nettype none

module rpi_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_x,
   input wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_y,
   input wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_x,
   input wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_y,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic                                  rsp_rays_meet,
   input wire logic                                  rsp_degenerate_ray
);

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a degenerate ray never reports a meeting
   a_degen_no_meet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate_ray) |-> !rsp_rays_meet)
      else $error("degenerate word reports a meeting");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_rays_meet) && $stable(rsp_degenerate_ray)))
      else $error("stalled response word changed");

   // an unstalled pipe delivers a degenerate first ray with no meeting
   a_degen_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_first_origin_x == req_first_through_x) &&
       (req_first_origin_y == req_first_through_y))
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> (rsp_valid && rsp_degenerate_ray && !rsp_rays_meet))
      else $error("degenerate word not delivered on time");

endmodule

bind ray_pair_intersection_test rpi_checker u_rpi_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_first_origin_x  (req_first_origin_x),
   .req_first_origin_y  (req_first_origin_y),
   .req_first_through_x (req_first_through_x),
   .req_first_through_y (req_first_through_y),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_rays_meet       (rsp_rays_meet),
   .rsp_degenerate_ray  (rsp_degenerate_ray)
);

`default_nettype wire

// ===== tb/ray_pair_intersection_test_checker.sv =====
`timescale 1ns / 1ps

module ray_pair_intersection_test_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_stall,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_y,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_y,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_origin_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_origin_y,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_through_x,
   input  wire logic signed [rpi_pkg::COORD_BITS-1:0] req_second_through_y,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic                                  rsp_rays_meet,
   input  wire logic                                  rsp_degenerate_ray,
   output int                                         mismatch_count,
   output int                                         answers_pending
);

   // verdicts still owed by the block, oldest first
   rpi_pkg::result_type expected_answers[$];
   rpi_pkg::coord_type  incoming;

   assign incoming = {req_first_origin_x, req_first_origin_y,
                      req_first_through_x, req_first_through_y,
                      req_second_origin_x, req_second_origin_y,
                      req_second_through_x, req_second_through_y};

   // 2-d cross product of two vectors
   function automatic longint cross_of(input longint ux, input longint uy,
                                       input longint vx, input longint vy);
      return ux * vy - uy * vx;
   endfunction

   // point p on the ray from o along nonzero direction d
   function automatic bit lies_on_ray(input longint ox, input longint oy,
                                      input longint dx, input longint dy,
                                      input longint px, input longint py);
      longint rx;
      longint ry;
      rx = px - ox;
      ry = py - oy;
      if (cross_of(dx, dy, rx, ry) != 0)
         return 1'b0;
      return (rx * dx + ry * dy) >= 0;
   endfunction

   // exact sign-based ray/ray meeting test
   function automatic rpi_pkg::result_type predict_meet(input rpi_pkg::coord_type w);
      rpi_pkg::result_type r;
      longint ax, ay, bx, by, cx, cy, qx, qy;
      longint d1x, d1y, d2x, d2y, wx, wy;
      longint den, nt, nu;
      bit t_ok;
      bit u_ok;
      ax = longint'($signed(w.ax));
      ay = longint'($signed(w.ay));
      bx = longint'($signed(w.bx));
      by = longint'($signed(w.by));
      cx = longint'($signed(w.cx));
      cy = longint'($signed(w.cy));
      qx = longint'($signed(w.dx));
      qy = longint'($signed(w.dy));
      d1x = bx - ax;
      d1y = by - ay;
      d2x = qx - cx;
      d2y = qy - cy;
      r.rays_meet      = 1'b0;
      r.degenerate_ray = 1'b0;
      // a ray with coincident points has no direction
      if ((d1x == 0 && d1y == 0) || (d2x == 0 && d2y == 0)) begin
         r.degenerate_ray = 1'b1;
         return r;
      end
      den = cross_of(d1x, d1y, d2x, d2y);
      if (den != 0) begin
         // crossing lines: both parameters must share the sign of den or be zero
         wx = cx - ax;
         wy = cy - ay;
         nt = cross_of(wx, wy, d2x, d2y);
         nu = cross_of(wx, wy, d1x, d1y);
         t_ok = (nt == 0) || ((nt > 0) == (den > 0));
         u_ok = (nu == 0) || ((nu > 0) == (den > 0));
         r.rays_meet = t_ok && u_ok;
      end else begin
         // parallel: meet only when one origin sits on the other ray
         r.rays_meet = lies_on_ray(ax, ay, d1x, d1y, cx, cy) ||
                       lies_on_ray(cx, cy, d2x, d2y, ax, ay);
      end
      return r;
   endfunction

   initial begin
      mismatch_count  = 0;
      answers_pending = 0;
   end

   // score each accepted result, then queue the prediction for an accepted word
   always @(posedge clock) begin : watch
      rpi_pkg::result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: result word with nothing expected: meet %0b degenerate %0b",
                        $time, rsp_rays_meet, rsp_degenerate_ray);
               mismatch_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_rays_meet !== want.rays_meet) begin
                  $display("%0t: rays_meet expected %0b actual %0b",
                           $time, want.rays_meet, rsp_rays_meet);
                  mismatch_count++;
               end
               if (rsp_degenerate_ray !== want.degenerate_ray) begin
                  $display("%0t: degenerate_ray expected %0b actual %0b",
                           $time, want.degenerate_ray, rsp_degenerate_ray);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_answers.push_back(predict_meet(incoming));
         answers_pending = expected_answers.size();
      end
   end

endmodule

// ===== tb/ray_pair_intersection_test_tb.sv =====
`timescale 1ns / 1ps

module ray_pair_intersection_test_tb;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_x;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_first_origin_y;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_x;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_first_through_y;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_second_origin_x;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_second_origin_y;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_second_through_x;
   logic signed [rpi_pkg::COORD_BITS-1:0] req_second_through_y;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic                                  rsp_rays_meet;
   logic                                  rsp_degenerate_ray;
   int                                    mismatch_count;
   int                                    answers_pending;

   // random gaps on both sides while set
   bit idling;
   // asks the receiver for one long hold-off
   bit hold_request;

   ray_pair_intersection_test uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_first_origin_x   (req_first_origin_x),
      .req_first_origin_y   (req_first_origin_y),
      .req_first_through_x  (req_first_through_x),
      .req_first_through_y  (req_first_through_y),
      .req_second_origin_x  (req_second_origin_x),
      .req_second_origin_y  (req_second_origin_y),
      .req_second_through_x (req_second_through_x),
      .req_second_through_y (req_second_through_y),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_rays_meet        (rsp_rays_meet),
      .rsp_degenerate_ray   (rsp_degenerate_ray)
   );

   ray_pair_intersection_test_checker scoreboard (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_first_origin_x   (req_first_origin_x),
      .req_first_origin_y   (req_first_origin_y),
      .req_first_through_x  (req_first_through_x),
      .req_first_through_y  (req_first_through_y),
      .req_second_origin_x  (req_second_origin_x),
      .req_second_origin_y  (req_second_origin_y),
      .req_second_through_x (req_second_through_x),
      .req_second_through_y (req_second_through_y),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_rays_meet        (rsp_rays_meet),
      .rsp_degenerate_ray   (rsp_degenerate_ray),
      .mismatch_count       (mismatch_count),
      .answers_pending      (answers_pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (100) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_stall <= idling && ($urandom_range(0, 99) < 37);
         end
      end
   end

   function automatic rpi_pkg::coord_type pair_of(input int ax, input int ay,
                                                  input int bx, input int by,
                                                  input int cx, input int cy,
                                                  input int qx, input int qy);
      rpi_pkg::coord_type w;
      w.ax = rpi_pkg::COORD_BITS'(ax);
      w.ay = rpi_pkg::COORD_BITS'(ay);
      w.bx = rpi_pkg::COORD_BITS'(bx);
      w.by = rpi_pkg::COORD_BITS'(by);
      w.cx = rpi_pkg::COORD_BITS'(cx);
      w.cy = rpi_pkg::COORD_BITS'(cy);
      w.dx = rpi_pkg::COORD_BITS'(qx);
      w.dy = rpi_pkg::COORD_BITS'(qy);
      return w;
   endfunction

   // uniform in -span..span
   function automatic int pick(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 6))
         0:       return -32768;
         1:       return -32767;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return 32766;
         default: return 32767;
      endcase
   endfunction

   // random ray pair, weighted toward parallel, collinear and touching shapes
   function automatic rpi_pkg::coord_type random_pair();
      int ax, ay, d1x, d1y, cx, cy, m, k;
      ax  = pick(20000);
      ay  = pick(20000);
      d1x = pick(100);
      d1y = pick(100);
      m   = pick(20);
      k   = pick(20);
      case ($urandom_range(0, 9))
         0, 1, 2:
            return pair_of(pick(32768), pick(32768), pick(32768), pick(32768),
                           pick(32768), pick(32768), pick(32768), pick(32768));
         3:
            return pair_of(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                           pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
         4:
            return pair_of(pick(3), pick(3), pick(3), pick(3),
                           pick(3), pick(3), pick(3), pick(3));
         5: begin
            // parallel, usually on a different line
            cx = pick(20000);
            cy = pick(20000);
            return pair_of(ax, ay, ax + d1x, ay + d1y, cx, cy, cx + k * d1x, cy + k * d1y);
         end
         6, 7: begin
            // collinear, either direction
            cx = ax + m * d1x;
            cy = ay + m * d1y;
            return pair_of(ax, ay, ax + d1x, ay + d1y, cx, cy, cx + k * d1x, cy + k * d1y);
         end
         8: begin
            // second origin on the first line, second direction free
            cx = ax + m * d1x;
            cy = ay + m * d1y;
            return pair_of(ax, ay, ax + d1x, ay + d1y, cx, cy, pick(32768), pick(32768));
         end
         default: begin
            if ($urandom_range(0, 1) == 1) begin
               return pair_of(ax, ay, ax, ay, pick(32768), pick(32768), pick(32768),
                              pick(32768));
            end
            return pair_of(pick(32768), pick(32768), pick(32768), pick(32768),
                           ax, ay, ax, ay);
         end
      endcase
   endfunction

   // offer one word and hold it until accepted; returns at a falling edge
   task automatic send_word(input rpi_pkg::coord_type w);
      while (idling && ($urandom_range(0, 99) < 37)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_first_origin_x   <= w.ax;
      req_first_origin_y   <= w.ay;
      req_first_through_x  <= w.bx;
      req_first_through_y  <= w.by;
      req_second_origin_x  <= w.cx;
      req_second_origin_y  <= w.cy;
      req_second_through_x <= w.dx;
      req_second_through_y <= w.dy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering until every expected word has come back
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(negedge clock);
      while (answers_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // stimulus and verdict
   initial begin
      int i;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_first_origin_x   = '0;
      req_first_origin_y   = '0;
      req_first_through_x  = '0;
      req_first_through_y  = '0;
      req_second_origin_x  = '0;
      req_second_origin_y  = '0;
      req_second_through_x = '0;
      req_second_through_y = '0;
      idling               = 1'b1;
      hold_request         = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // degenerate rays
      send_word(pair_of(5, 5, 5, 5, 0, 0, 1, 1));
      send_word(pair_of(0, 0, 1, 1, -7, 3, -7, 3));
      send_word(pair_of(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
      send_word(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
      // crossing lines: hit, behind either origin, zero parameter on either ray
      send_word(pair_of(0, 0, 2, 2, 0, 2, 2, 0));
      send_word(pair_of(0, 0, 1, 1, 0, -2, -1, -2));
      send_word(pair_of(0, 0, 1, 0, 5, 5, 5, 6));
      send_word(pair_of(3, 3, 4, 3, 3, 0, 3, 1));
      send_word(pair_of(0, 0, 1, 0, 5, 0, 5, 1));
      send_word(pair_of(0, 0, 1, 1, 2, 2, 3, 1));
      // parallel and collinear
      send_word(pair_of(0, 0, 1, 0, 5, 0, 6, 0));
      send_word(pair_of(0, 0, -1, 0, 5, 0, 6, 0));
      send_word(pair_of(0, 0, 1, 0, 5, 0, 4, 0));
      send_word(pair_of(2, 2, 3, 3, 2, 2, 1, 1));
      send_word(pair_of(0, 0, 1, 1, 0, 1, 1, 2));
      send_word(pair_of(0, 0, 1, 0, 0, 1, -1, 1));
      // coordinate extremes
      send_word(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      send_word(pair_of(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
      send_word(pair_of(-32768, 0, -32767, 0, 32767, 1, 32767, 2));
      send_word(pair_of(-1, -1, 32767, -32768, 0, 0, -32768, 32767));
      drain_pipe();

      // long receiver hold-off while words keep coming, so the pipe backs up
      idling       = 1'b0;
      hold_request = 1'b1;
      for (i = 0; i < 40; i++)
         send_word(random_pair());
      drain_pipe();

      // random traffic with a stretch of back-to-back words in the middle
      for (i = 0; i < 1600; i++) begin
         idling = !(i >= 500 && i < 900);
         if (i == 1100)
            drain_pipe();
         send_word(random_pair());
      end
      idling = 1'b1;
      drain_pipe();

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
